// File: design/bsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banker's safety check package
// Shared codes, default sizes and the result record of the safety check unit.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int DEF_NUM_PROCS   = 8;
    localparam int DEF_NUM_RES     = 4;
    localparam int DEF_COUNT_WIDTH = 8;

    localparam logic [2:0] CMD_LOAD     = 3'd0;
    localparam logic [2:0] CMD_AVAIL    = 3'd1;
    localparam logic [2:0] CMD_REQ      = 3'd2;
    localparam logic [2:0] CMD_CHECK    = 3'd3;
    localparam logic [2:0] CMD_SUBMIT   = 3'd4;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_ENTRY   = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVER_MAX  = 3'd1;
    localparam logic [2:0] ST_OVER_NEED = 3'd2;
    localparam logic [2:0] ST_OVER_AVL  = 3'd3;
    localparam logic [2:0] ST_ROLLBACK  = 3'd4;

    localparam logic       CFG_PROCS    = 1'b0;
    localparam logic       CFG_RES      = 1'b1;

    localparam logic [3:0] PROCS_RESET  = 4'd8;
    localparam logic [2:0] RES_RESET    = 3'd4;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] proc_index;
        logic       safe;
        logic [2:0] status;
        logic       last;
    } t_result;

endpackage

// File: design/bsc_tables.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocation and need tables
// Two synchronous memories sharing one write port and one registered read port.
// ----------------------------------------------------------------------------
module bsc_tables #(
    parameter int NUM_PROCS   = 8,
    parameter int NUM_RES     = 4,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [$clog2(NUM_PROCS*NUM_RES)-1:0]  i_waddr,
    input  logic [COUNT_WIDTH-1:0]                i_walloc,
    input  logic [COUNT_WIDTH-1:0]                i_wneed,
    input  logic [$clog2(NUM_PROCS*NUM_RES)-1:0]  i_raddr,
    output logic [COUNT_WIDTH-1:0]                o_ralloc,
    output logic [COUNT_WIDTH-1:0]                o_rneed
);
    localparam int DEPTH = NUM_PROCS * NUM_RES;

    logic [COUNT_WIDTH-1:0] r_alloc_mem [DEPTH];
    logic [COUNT_WIDTH-1:0] r_need_mem  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_alloc_mem[i_waddr] <= i_walloc;
            r_need_mem[i_waddr]  <= i_wneed;
        end
        o_ralloc <= r_alloc_mem[i_raddr];
        o_rneed  <= r_need_mem[i_raddr];
    end

endmodule

// File: design/bsc_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output register
// Holds one result for the master stream and packs it onto the bus.
// ----------------------------------------------------------------------------
module bsc_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  bsc_pkg::t_result i_res,
    output logic             o_can_load,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // proc_index[2:0], safe[3], status[6:4], zero[7]
    output logic [1:0]       m_tuser,   // kind[1:0]
    output logic             m_tlast
);
    import bsc_pkg::*;

    t_result r_res;
    logic    r_valid;

    assign o_can_load = !r_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

    assign m_tvalid = r_valid;
    assign m_tdata  = {1'b0, r_res.status, r_res.safe, r_res.proc_index};
    assign m_tuser  = r_res.kind;
    assign m_tlast  = r_res.last;

endmodule

// File: design/bankers_safety_check_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banker's safety check unit
// Table loads, request submission and the deadlock-avoidance safety scan.
// ----------------------------------------------------------------------------
// Input items arrive on the slave stream: s_tuser carries the command and
// s_tdata the process, resource and count operands. Results leave on the
// master stream, one transfer each; m_tlast marks the final result of an item.
// The configuration channel sets the process and resource counts in use; the
// user must write it only while the unit is idle, which the unit does not
// enforce; it is always ready. One item is handled at a time. The acknowledge
// of a load, available or request write passes through the result record and
// the output register to the master stream, and the next item is taken once
// the acknowledge has moved into the output register. A submit reads and
// compares one need element at a time and a grant reads and rewrites one
// element at a time. The safety scan visits the processes in turn, compares
// the need elements of each unfinished one with the work vector one by one,
// adds its allocation elements one by one and emits a sequence entry for it;
// the single read port of the tables sets this pace.
// A finished result sits in the output register while the next one is being
// computed; a stalled receiver holds the sequencer before its next result.
// Reset clears the sequencer, finished flags, work vector and output valid flag
// and sets the counts in use to defaults; the tables hold nothing defined until loaded.
// ----------------------------------------------------------------------------
module bankers_safety_check_unit #(
    parameter int NUM_PROCS   = bsc_pkg::DEF_NUM_PROCS,
    parameter int NUM_RES     = bsc_pkg::DEF_NUM_RES,
    parameter int COUNT_WIDTH = bsc_pkg::DEF_COUNT_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // proc_sel[2:0], res_sel[4:3], alloc_count[12:5], max_count[20:13],
    // amount[28:21], zero[31:29]
    input  logic [31:0] s_tdata,
    input  logic [2:0]  s_tuser,    // command[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // proc_index[2:0], safe[3], status[6:4], zero[7]
    output logic [1:0]  m_tuser,    // kind[1:0]
    output logic        m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    import bsc_pkg::*;

    localparam int PW  = $clog2(NUM_PROCS);
    localparam int PCW = $clog2(NUM_PROCS + 1);
    localparam int RW  = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
    localparam int RCW = $clog2(NUM_RES + 1);
    localparam int AW  = $clog2(NUM_PROCS * NUM_RES);
    localparam int CW  = COUNT_WIDTH;
    localparam int WW  = COUNT_WIDTH + $clog2(NUM_PROCS + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EMIT     = 4'd1;
    localparam logic [3:0] S_ND_RD    = 4'd2;
    localparam logic [3:0] S_ND_CMP   = 4'd3;
    localparam logic [3:0] S_GR_RD    = 4'd4;
    localparam logic [3:0] S_GR_WR    = 4'd5;
    localparam logic [3:0] S_SC_START = 4'd6;
    localparam logic [3:0] S_SC_PROC  = 4'd7;
    localparam logic [3:0] S_SC_RD    = 4'd8;
    localparam logic [3:0] S_SC_CMP   = 4'd9;
    localparam logic [3:0] S_AD_RD    = 4'd10;
    localparam logic [3:0] S_AD_ADD   = 4'd11;
    localparam logic [3:0] S_SC_END   = 4'd12;
    localparam logic [3:0] S_RB_RD    = 4'd13;
    localparam logic [3:0] S_RB_WR    = 4'd14;

    logic [3:0]         r_state;
    logic [3:0]         r_ret;
    t_result            r_res;
    logic [2:0]         r_cmd;
    logic [PW-1:0]      r_sp;
    logic [PCW-1:0]     r_q;
    logic [PCW-1:0]     r_done;
    logic               r_prog;
    logic               r_safe;
    logic [RW-1:0]      r_r;
    logic [NUM_PROCS-1:0] r_fin;
    logic [WW-1:0]      r_work  [NUM_RES];
    logic [CW-1:0]      r_avail [NUM_RES];
    logic [CW-1:0]      r_req   [NUM_RES];
    logic [3:0]         r_procs;
    logic [2:0]         r_resn;

    logic [2:0]    in_cmd;
    logic [2:0]    in_ps;
    logic [1:0]    in_rs;
    logic [CW-1:0] in_ac;
    logic [CW-1:0] in_mc;
    logic [CW-1:0] in_am;
    logic          pok;
    logic          rok;
    logic          in_acc;
    logic          load_over_max;
    logic [PCW-1:0] np;
    logic [RCW-1:0] nr;
    logic          is_last_res;
    logic          over_avail;
    logic [PW-1:0] addr_p;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          mem_we;
    logic [CW-1:0] wr_alloc;
    logic [CW-1:0] wr_need;
    logic [CW-1:0] rd_alloc;
    logic [CW-1:0] rd_need;
    logic          out_can_load;
    logic          out_load;

    assign in_cmd = s_tuser;
    assign in_ps  = s_tdata[2:0];
    assign in_rs  = s_tdata[4:3];
    assign in_ac  = CW'(s_tdata[12:5]);
    assign in_mc  = CW'(s_tdata[20:13]);
    assign in_am  = CW'(s_tdata[28:21]);
    assign pok    = int'(in_ps) < NUM_PROCS;
    assign rok    = int'(in_rs) < NUM_RES;

    assign s_tready    = (r_state == S_IDLE);
    assign in_acc      = s_tvalid && s_tready;
    assign o_cfg_ready = 1'b1;

    assign load_over_max = (in_cmd == CMD_LOAD) && pok && rok && (in_ac > in_mc);

    always_comb begin
        if (r_procs == 4'd0) begin
            np = PCW'(1);
        end else if (int'(r_procs) > NUM_PROCS) begin
            np = PCW'(NUM_PROCS);
        end else begin
            np = PCW'(r_procs);
        end
        if (r_resn == 3'd0) begin
            nr = RCW'(1);
        end else if (int'(r_resn) > NUM_RES) begin
            nr = RCW'(NUM_RES);
        end else begin
            nr = RCW'(r_resn);
        end
    end

    assign is_last_res = (int'(r_r) + 1) == int'(nr);

    always_comb begin
        over_avail = 1'b0;
        for (int i = 0; i < NUM_RES; i++) begin
            if (i < int'(nr) && r_req[i] > r_avail[i]) begin
                over_avail = 1'b1;
            end
        end
    end

    assign addr_p = (r_state == S_SC_RD || r_state == S_AD_RD) ? r_q[PW-1:0] : r_sp;
    assign rd_addr = AW'(int'(addr_p) * NUM_RES + int'(r_r));

    always_comb begin
        mem_we   = 1'b0;
        wr_addr  = rd_addr;
        wr_alloc = rd_alloc + r_req[r_r];
        wr_need  = rd_need - r_req[r_r];
        unique case (r_state)
            S_IDLE: begin
                wr_addr  = AW'(int'(in_ps) * NUM_RES + int'(in_rs));
                wr_alloc = in_ac;
                wr_need  = in_mc - in_ac;
                mem_we   = in_acc && in_cmd == CMD_LOAD && pok && rok && !(in_ac > in_mc);
            end
            S_GR_WR: begin
                mem_we = 1'b1;
            end
            S_RB_WR: begin
                mem_we   = 1'b1;
                wr_alloc = rd_alloc - r_req[r_r];
                wr_need  = rd_need + r_req[r_r];
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    bsc_tables #(
        .NUM_PROCS   (NUM_PROCS),
        .NUM_RES     (NUM_RES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tables (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (wr_addr),
        .i_walloc (wr_alloc),
        .i_wneed  (wr_need),
        .i_raddr  (rd_addr),
        .o_ralloc (rd_alloc),
        .o_rneed  (rd_need)
    );

    assign out_load = (r_state == S_EMIT);

    bsc_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (out_load),
        .i_res      (r_res),
        .o_can_load (out_can_load),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_fin   <= '0;
            r_procs <= PROCS_RESET;
            r_resn  <= RES_RESET;
            for (int i = 0; i < NUM_RES; i++) begin
                r_work[i] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_PROCS: r_procs <= i_cfg_data;
                    CFG_RES:   r_resn  <= i_cfg_data[2:0];
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd <= in_cmd;
                        r_res <= '{kind: KIND_ACK, proc_index: 3'd0, safe: 1'b0,
                                   status: load_over_max ? ST_OVER_MAX : ST_OK,
                                   last: 1'b1};
                        r_ret <= S_IDLE;
                        unique case (in_cmd)
                            CMD_AVAIL: begin
                                if (rok) begin
                                    r_avail[RW'(in_rs)] <= in_am;
                                end
                                r_state <= S_EMIT;
                            end
                            CMD_REQ: begin
                                if (rok) begin
                                    r_req[RW'(in_rs)] <= in_am;
                                end
                                r_state <= S_EMIT;
                            end
                            CMD_CHECK: begin
                                r_state <= S_SC_START;
                            end
                            CMD_SUBMIT: begin
                                if (pok) begin
                                    r_sp    <= PW'(in_ps);
                                    r_r     <= '0;
                                    r_state <= S_ND_RD;
                                end else begin
                                    r_state <= S_EMIT;
                                end
                            end
                            default: begin
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_EMIT: begin
                    if (out_can_load) begin
                        r_state <= r_ret;
                    end
                end
                S_ND_RD: begin
                    r_state <= S_ND_CMP;
                end
                S_ND_CMP: begin
                    if (r_req[r_r] > rd_need) begin
                        r_res.status <= ST_OVER_NEED;
                        r_state <= S_EMIT;
                    end else if (is_last_res) begin
                        r_r <= '0;
                        if (over_avail) begin
                            r_res.status <= ST_OVER_AVL;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_GR_RD;
                        end
                    end else begin
                        r_r <= r_r + 1'b1;
                        r_state <= S_ND_RD;
                    end
                end
                S_GR_RD: begin
                    r_state <= S_GR_WR;
                end
                S_GR_WR: begin
                    r_avail[r_r] <= r_avail[r_r] - r_req[r_r];
                    if (is_last_res) begin
                        r_r <= '0;
                        r_state <= S_SC_START;
                    end else begin
                        r_r <= r_r + 1'b1;
                        r_state <= S_GR_RD;
                    end
                end
                S_SC_START: begin
                    r_fin  <= '0;
                    r_q    <= '0;
                    r_done <= '0;
                    r_prog <= 1'b0;
                    for (int i = 0; i < NUM_RES; i++) begin
                        r_work[i] <= WW'(r_avail[i]);
                    end
                    r_state <= S_SC_PROC;
                end
                S_SC_PROC: begin
                    if (r_q == np) begin
                        if (!r_prog) begin
                            r_safe  <= 1'b0;
                            r_state <= S_SC_END;
                        end else begin
                            r_q    <= '0;
                            r_prog <= 1'b0;
                        end
                    end else if (r_fin[r_q[PW-1:0]]) begin
                        r_q <= r_q + 1'b1;
                    end else begin
                        r_r <= '0;
                        r_state <= S_SC_RD;
                    end
                end
                S_SC_RD: begin
                    r_state <= S_SC_CMP;
                end
                S_SC_CMP: begin
                    if (WW'(rd_need) > r_work[r_r]) begin
                        r_q <= r_q + 1'b1;
                        r_state <= S_SC_PROC;
                    end else if (is_last_res) begin
                        r_r <= '0;
                        r_state <= S_AD_RD;
                    end else begin
                        r_r <= r_r + 1'b1;
                        r_state <= S_SC_RD;
                    end
                end
                S_AD_RD: begin
                    r_state <= S_AD_ADD;
                end
                S_AD_ADD: begin
                    r_work[r_r] <= r_work[r_r] + WW'(rd_alloc);
                    if (is_last_res) begin
                        r_fin[r_q[PW-1:0]] <= 1'b1;
                        r_done <= r_done + 1'b1;
                        r_prog <= 1'b1;
                        r_q    <= r_q + 1'b1;
                        r_res  <= '{kind: KIND_ENTRY, proc_index: 3'(r_q), safe: 1'b0,
                                    status: ST_OK, last: 1'b0};
                        if (r_done + 1'b1 == np) begin
                            r_safe <= 1'b1;
                            r_ret  <= S_SC_END;
                        end else begin
                            r_ret  <= S_SC_PROC;
                        end
                        r_state <= S_EMIT;
                    end else begin
                        r_r <= r_r + 1'b1;
                        r_state <= S_AD_RD;
                    end
                end
                S_SC_END: begin
                    if (r_cmd == CMD_SUBMIT && !r_safe) begin
                        r_r <= '0;
                        r_state <= S_RB_RD;
                    end else begin
                        r_res <= '{kind: KIND_VERDICT, proc_index: 3'd0, safe: r_safe,
                                   status: ST_OK, last: 1'b1};
                        r_ret <= S_IDLE;
                        r_state <= S_EMIT;
                    end
                end
                S_RB_RD: begin
                    r_state <= S_RB_WR;
                end
                S_RB_WR: begin
                    r_avail[r_r] <= r_avail[r_r] + r_req[r_r];
                    if (is_last_res) begin
                        r_res <= '{kind: KIND_VERDICT, proc_index: 3'd0, safe: 1'b0,
                                   status: ST_ROLLBACK, last: 1'b1};
                        r_ret <= S_IDLE;
                        r_state <= S_EMIT;
                    end else begin
                        r_r <= r_r + 1'b1;
                        r_state <= S_RB_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/bsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Safety check unit port checker
// Watches the stream ports of the unit and flags results that break its rules.
// ----------------------------------------------------------------------------
module bsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);
    import bsc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new item taken while one is in work");

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tlast |-> m_tuser == KIND_ENTRY)
        else $error("only sequence entries may be non-final");

    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == KIND_ENTRY |-> !m_tlast && m_tdata[6:3] == 4'd0)
        else $error("sequence entry with verdict fields set");

endmodule

bind bankers_safety_check_unit bsc_checker u_bsc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
